>>> sv/aes_pkg.sv
package aes_pkg;

    localparam int RK_DEPTH = 60;
    localparam int RK_AW    = 6;

    localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_KEY_LAST   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_LOAD,
        ST_KEY_EXP,
        ST_RK_FETCH,
        ST_FIRST,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef logic [7:0] t_byte;

    function automatic t_byte sbox(input t_byte a);
        t_byte t [256] = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic t_byte inv_sbox(input t_byte a);
        t_byte t [256] = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return t[a];
    endfunction

    function automatic t_byte xt(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        t_byte a0, a1, a2, a3, b0, b1, b2, b3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        if (inv) begin
            u = xt(xt(a0 ^ a2));
            v = xt(xt(a1 ^ a3));
            a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
        end
        b0 = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        b1 = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        b2 = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        b3 = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        return {b0, b1, b2, b3};
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [1:0]   src;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                src = inv ? 2'(c + 4 - k) : 2'(c + k);
                r[127 - 8*(4*c + k) -: 8] = inv ? inv_sbox(s[127 - 8*(4*int'(src) + k) -: 8])
                                                : sbox(s[127 - 8*(4*int'(src) + k) -: 8]);
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
            r[127 - 32*c -: 32] = mix_col(s[127 - 32*c -: 32], inv);
        return r;
    endfunction

endpackage

>>> sv/aes_key_store.sv
module aes_key_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [aes_pkg::RK_AW-1:0]  i_waddr,
    input  logic [31:0]                i_wdata,
    input  logic [aes_pkg::RK_AW-1:0]  i_raddr,
    output logic [31:0]                o_rdata
);
    import aes_pkg::*;

    logic [31:0] r_mem [RK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/aes_block_cipher_top.sv
// Key schedule (first block after reset or a write to the key length or a key word): the
// 4*(Nr+1) round-key words are written, one round-key word a cycle through the single store write port.
// Block: Nr+1 passes from input to result valid (Nr=10/12/14), each of four round-key word
// reads, one read wait and one round unit step.
// One block at a time; the result holds until transferred.
// Synchronous active-low reset clears the key flag, the key and key-length registers and the control state.
module aes_block_cipher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);
    import aes_pkg::*;

    t_state r_state, n_state;
    logic [1:0]   r_klen;
    logic [63:0]  r_key [4];
    logic         r_keys_ready;
    logic         r_dec;
    logic [127:0] r_s, n_s;
    logic [127:0] r_rk;
    logic [RK_AW-1:0] r_idx, n_idx;
    logic [RK_AW-1:0] r_ridx, n_ridx;
    logic [3:0]   r_round, n_round;
    logic [1:0]   r_col, n_col;
    logic [7:0]   r_rc, n_rc;
    logic [31:0]  r_w [8];
    logic [2:0]   r_kpos, n_kpos;

    logic [3:0]   nk, nr;
    logic [RK_AW-1:0] total;
    logic         mem_we;
    logic [31:0]  mem_wdata, mem_rdata, t_w;
    logic         rd_issue;
    logic         rk_valid_d;

    always_comb begin
        case (r_klen)
            2'd1: begin nk = 4'd6; nr = 4'd12; end
            2'd2: begin nk = 4'd8; nr = 4'd14; end
            default: begin nk = 4'd4; nr = 4'd10; end
        endcase
        total = RK_AW'({nr, 2'b00} + 6'd4);
    end

    aes_key_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (mem_wdata),
        .i_raddr (r_ridx),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        t_w = r_w[nk[2:0] - 3'd1];
        if (r_kpos == 3'd0) begin
            t_w = sbox_word({t_w[23:0], t_w[31:24]}) ^ {r_rc, 24'd0};
        end else if (nk == 4'd8 && r_kpos == 3'd4) begin
            t_w = sbox_word(t_w);
        end
        mem_wdata = (r_state == ST_KEY_LOAD) ? r_w[r_idx[2:0]] : (r_w[0] ^ t_w);
    end

    always_comb begin
        n_state  = r_state;
        n_s      = r_s;
        n_idx    = r_idx;
        n_ridx   = r_ridx;
        n_round  = r_round;
        n_col    = r_col;
        n_rc     = r_rc;
        n_kpos   = r_kpos;
        mem_we   = 1'b0;
        rd_issue = 1'b0;
        o_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_s = {i_block_high, i_block_low};
                    n_idx = '0;
                    n_rc = 8'h01;
                    n_state = r_keys_ready ? ST_RK_FETCH : ST_KEY_LOAD;
                    n_round = i_action ? nr : 4'd0;
                    n_col = 2'd0;
                    n_ridx = i_action ? RK_AW'({nr, 2'b00}) : '0;
                end
            end
            ST_KEY_LOAD: begin
                mem_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if ({2'b00, r_idx} == {1'b0, nk} - 5'd1) begin
                    n_kpos = 3'd0;
                    n_state = ST_KEY_EXP;
                end
            end
            ST_KEY_EXP: begin
                mem_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_kpos == 3'd0) n_rc = xt(r_rc);
                n_kpos = (r_kpos == nk[2:0] - 3'd1) ? 3'd0 : r_kpos + 3'd1;
                if (n_idx == total) begin
                    n_state = ST_RK_FETCH;
                    n_col = 2'd0;
                end
            end
            ST_RK_FETCH: begin
                rd_issue = 1'b1;
                n_ridx = r_ridx + 1'b1;
                n_col = r_col + 2'd1;
                if (r_col == 2'd3) n_state = ST_FIRST;
            end
            ST_FIRST: begin
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_round == (r_dec ? nr : 4'd0)) begin
                    n_s = r_s ^ r_rk;
                end else if (!r_dec) begin
                    n_s = (r_round == nr) ? (sub_shift(r_s, 1'b0) ^ r_rk)
                                          : (mix_all(sub_shift(r_s, 1'b0), 1'b0) ^ r_rk);
                end else begin
                    n_s = sub_shift(r_s, 1'b1) ^ r_rk;
                    if (r_round != 4'd0) n_s = mix_all(n_s, 1'b1);
                end
                if (r_round == (r_dec ? 4'd0 : nr)) begin
                    n_state = ST_DONE;
                end else begin
                    n_round = r_dec ? r_round - 4'd1 : r_round + 4'd1;
                    n_ridx = r_dec ? RK_AW'({r_round - 4'd1, 2'b00})
                                   : RK_AW'({r_round + 4'd1, 2'b00});
                    n_col = 2'd0;
                    n_state = ST_RK_FETCH;
                end
            end
            ST_DONE: begin
                if (i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_keys_ready <= 1'b0;
            r_klen <= '0;
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
            rk_valid_d <= 1'b0;
        end else begin
            r_state <= n_state;
            rk_valid_d <= rd_issue;
            if (r_state == ST_KEY_EXP && n_state == ST_RK_FETCH) r_keys_ready <= 1'b1;
            if (i_cfg_we && i_cfg_index <= CFG_KEY_LAST) begin
                r_keys_ready <= 1'b0;
                if (i_cfg_index == CFG_KEY_LENGTH) r_klen <= i_cfg_data[1:0];
                else r_key[2'(i_cfg_index - 3'd1)] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        r_idx <= n_idx;
        r_ridx <= n_ridx;
        r_round <= n_round;
        r_col <= n_col;
        r_rc <= n_rc;
        r_kpos <= n_kpos;
        if (rk_valid_d) r_rk <= {r_rk[95:0], mem_rdata};
        if (r_state == ST_IDLE && i_valid) begin
            r_dec <= i_action;
            for (int k = 0; k < 8; k++)
                r_w[k] <= k[0] ? r_key[k/2][31:0] : r_key[k/2][63:32];
        end else if (mem_we) begin
            if (r_state == ST_KEY_EXP) begin
                for (int k = 0; k < 8; k++)
                    r_w[k] <= (3'(k) == nk[2:0] - 3'd1) ? mem_wdata : r_w[3'(k + 1)];
            end
        end
    end

    assign o_valid = (r_state == ST_DONE);
    assign o_result_high = r_s[127:64];
    assign o_result_low  = r_s[63:0];

endmodule

>>> sv/aes_checker.sv
module aes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_result_high,
    input logic [63:0] o_result_low
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_high) && $stable(o_result_low))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input open while result pending");

    a_no_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid)
        else $error("result too early");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind aes_block_cipher_top aes_checker u_aes_checker (.*);

>>> tb/aes_block_cipher_top_tb.sv
module aes_block_cipher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] CFG_KEY_0_7   = 3'd1;
    localparam logic [2:0] CFG_KEY_8_15  = 3'd2;
    localparam logic [2:0] CFG_KEY_16_23 = 3'd3;
    localparam logic [2:0] CFG_KEY_24_31 = 3'd4;
    localparam logic [2:0] CFG_BEYOND    = 3'd5;
    localparam logic       ACT_ENC = 1'b0;
    localparam logic       ACT_DEC = 1'b1;

    typedef struct packed {
        logic        action;
        logic [63:0] blk_hi;
        logic [63:0] blk_lo;
    } t_block_req;

    typedef struct packed {
        logic [63:0] res_hi;
        logic [63:0] res_lo;
    } t_block_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = 1'b0;
    logic [63:0] i_block_high = '0;
    logic [63:0] i_block_low = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_result_high;
    logic [63:0] o_result_low;

    aes_block_cipher_top uut (.*);

    always #1 i_clk = ~i_clk;

    logic [1:0]  key_len_q;
    logic [63:0] key_reg_q [4];
    logic [31:0] sched_q [60];
    logic        sched_ok_q;

    t_block_req  pending_q [$];
    t_block_res  cipher_exp_q [$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          recv_hold = 1'b0;
    int          hold_cycles = 0;
    int          n_errors = 0;
    int          n_blocks_in = 0;
    int          n_blocks_out = 0;
    int          n_dec = 0;
    int          quiet_cycles = 0;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] fwd_sub(input logic [7:0] x);
        logic [7:0] inv, r;
        inv = 8'h00;
        if (x != 0) begin
            inv = x;
            for (int k = 0; k < 253; k++) inv = gf_mul(inv, x);
        end
        r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return r;
    endfunction

    logic [7:0] fwd_tab [256];
    logic [7:0] rev_tab [256];

    function automatic logic [31:0] sub4(input logic [31:0] w);
        return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
    endfunction

    function automatic void expand_schedule();
        int nk, nr;
        logic [7:0]  rc;
        logic [31:0] t;
        nk = (key_len_q == 2'd1) ? 6 : (key_len_q == 2'd2) ? 8 : 4;
        nr = nk + 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched_q[i] = i[0] ? key_reg_q[i >> 1][31:0] : key_reg_q[i >> 1][63:32];
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            t = sched_q[i - 1];
            if (i % nk == 0) begin
                t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end else if (nk > 6 && i % nk == 4) begin
                t = sub4(t);
            end
            sched_q[i] = sched_q[i - nk] ^ t;
        end
        sched_ok_q = 1'b1;
    endfunction

    function automatic void add_round(ref logic [7:0] s [16], input int rnd);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[4*c + r] ^= sched_q[rnd*4 + c][31 - 8*r -: 8];
    endfunction

    function automatic void subst_rows(ref logic [7:0] s [16], input logic dec);
        logic [7:0] t [16];
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                src = dec ? ((c + 4 - r) & 3) : ((c + r) & 3);
                t[4*c + r] = dec ? rev_tab[s[4*src + r]] : fwd_tab[s[4*src + r]];
            end
        s = t;
    endfunction

    function automatic void mix_cols(ref logic [7:0] s [16], input logic dec);
        logic [7:0] m [4];
        logic [7:0] col [4];
        logic [7:0] acc;
        if (dec) m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) col[r] = s[4*c + r];
            for (int r = 0; r < 4; r++) begin
                acc = '0;
                for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], m[(k + 4 - r) & 3]);
                s[4*c + r] = acc;
            end
        end
    endfunction

    function automatic t_block_res cipher_block(input t_block_req q);
        logic [7:0] s [16];
        int nr;
        t_block_res res;
        if (!sched_ok_q) expand_schedule();
        nr = (key_len_q == 2'd1) ? 12 : (key_len_q == 2'd2) ? 14 : 10;
        for (int i = 0; i < 8; i++) begin
            s[i]     = q.blk_hi[63 - 8*i -: 8];
            s[i + 8] = q.blk_lo[63 - 8*i -: 8];
        end
        if (q.action == ACT_ENC) begin
            add_round(s, 0);
            for (int r = 1; r < nr; r++) begin
                subst_rows(s, 1'b0);
                mix_cols(s, 1'b0);
                add_round(s, r);
            end
            subst_rows(s, 1'b0);
            add_round(s, nr);
        end else begin
            add_round(s, nr);
            for (int r = nr - 1; r >= 1; r--) begin
                subst_rows(s, 1'b1);
                add_round(s, r);
                mix_cols(s, 1'b1);
            end
            subst_rows(s, 1'b1);
            add_round(s, 0);
        end
        for (int i = 0; i < 8; i++) begin
            res.res_hi[63 - 8*i -: 8] = s[i];
            res.res_lo[63 - 8*i -: 8] = s[i + 8];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid && o_ready) begin
                cipher_exp_q.push_back(cipher_block(
                    '{action: i_action, blk_hi: i_block_high, blk_lo: i_block_low}));
                n_blocks_in++;
                if (i_action == ACT_DEC) n_dec++;
            end
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid      <= 1'b1;
                i_action     <= pending_q[0].action;
                i_block_high <= pending_q[0].blk_hi;
                i_block_low  <= pending_q[0].blk_lo;
                void'(pending_q.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_blocks_out++;
                if (cipher_exp_q.size() == 0) begin
                    $error("result with nothing expected: %h %h", o_result_high, o_result_low);
                    n_errors++;
                end else begin
                    if (o_result_high !== cipher_exp_q[0].res_hi) begin
                        $error("result_high expected %h got %h",
                               cipher_exp_q[0].res_hi, o_result_high);
                        n_errors++;
                    end
                    if (o_result_low !== cipher_exp_q[0].res_lo) begin
                        $error("result_low expected %h got %h",
                               cipher_exp_q[0].res_lo, o_result_low);
                        n_errors++;
                    end
                    void'(cipher_exp_q.pop_front());
                end
            end
            if (recv_hold) begin
                hold_cycles++;
                if (hold_cycles >= 300) begin
                    recv_hold <= 1'b0;
                    hold_cycles = 0;
                end
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("aes_block_cipher_top_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_KEY_LENGTH) key_len_q = val[1:0];
        else if (idx <= CFG_KEY_LAST) key_reg_q[idx - 1] = val;
        if (idx <= CFG_KEY_LAST) sched_ok_q = 1'b0;
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !i_valid && cipher_exp_q.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [1:0] len, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        drain();
        write_reg(CFG_KEY_LENGTH, {62'd0, len});
        write_reg(CFG_KEY_0_7, k0);
        write_reg(CFG_KEY_8_15, k1);
        write_reg(CFG_KEY_16_23, k2);
        write_reg(CFG_KEY_24_31, k3);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pending_q.push_back('{action: 1'($urandom_range(0, 1)), blk_hi: rand64(),
                                  blk_lo: rand64()});
    endtask

    initial begin
        for (int v = 0; v < 256; v++) fwd_tab[v] = fwd_sub(v[7:0]);
        for (int v = 0; v < 256; v++) rev_tab[fwd_tab[v]] = v[7:0];
        key_len_q = '0;
        for (int i = 0; i < 4; i++) key_reg_q[i] = '0;
        sched_ok_q = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_q.push_back('{ACT_ENC, 64'h0, 64'h0});
        pending_q.push_back('{ACT_DEC, 64'h0, 64'h0});
        load_key(2'd0, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '1, '1);
        pending_q.push_back('{ACT_ENC, 64'h3243f6a8885a308d, 64'h313198a2e0370734});
        pending_q.push_back('{ACT_DEC, 64'h3925841d02dc09fb, 64'hdc118597196a0b32});
        pending_q.push_back('{ACT_ENC, '1, '1});
        pending_q.push_back('{ACT_DEC, '1, '1});
        load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
        pending_q.push_back('{ACT_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff});
        pending_q.push_back('{ACT_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191});
        load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        pending_q.push_back('{ACT_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff});
        pending_q.push_back('{ACT_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089});
        load_key(2'd3, '1, '1, '1, '1);
        pending_q.push_back('{ACT_ENC, 64'h8000000000000000, 64'h1});
        pending_q.push_back('{ACT_DEC, 64'h1, 64'h8000000000000000});
        drain();
        write_reg(CFG_KEY_0_7, key_reg_q[0]);
        pending_q.push_back('{ACT_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210});
        drain();
        write_reg(CFG_BEYOND, '1);
        pending_q.push_back('{ACT_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210});

        for (int ph = 0; ph < 8; ph++) begin
            load_key(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (ph == 2) recv_hold = 1'b1;
            queue_random(135);
        end
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(5);
        drain();
        $display("blocks sent %0d, results checked %0d, decrypts %0d, key sizes 128/192/256",
                 n_blocks_in, n_blocks_out, n_dec);
        $display("idle and stall mixes, a long receiver hold and key reloads covered");
        if (n_errors == 0)
            $display("aes_block_cipher_top_tb: clean");
        else
            $display("aes_block_cipher_top_tb: errors");
        $finish;
    end
endmodule
